// ----- hw/rtl/iir4_pkg.sv -----
// ----------------------------------------------------------------------------
// iir4_pkg
// shared types and constants of the fourth-order df2t iir filter
// ----------------------------------------------------------------------------
package iir4_pkg;

   localparam int SAMPLE_W   = 16;
   localparam int COEF_W     = 24;
   localparam int COEF_N     = 9;
   localparam int REG_W      = 48;
   localparam int A4_W       = 24;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 6;
   localparam int REG_IDX_W  = 3;
   localparam int PROD_W     = COEF_W + SAMPLE_W;
   localparam int DELAY_W    = 42;
   localparam int ACC_W      = 44;
   localparam int DELAY_N    = 4;
   localparam int DLY_IDX_W  = 2;
   localparam int FRAC_SHIFT = 20;

   // register indexes on the configuration port
   localparam logic [REG_IDX_W-1:0] REG_B0_B1 = 3'd0;
   localparam logic [REG_IDX_W-1:0] REG_B2_B3 = 3'd1;
   localparam logic [REG_IDX_W-1:0] REG_B4_A1 = 3'd2;
   localparam logic [REG_IDX_W-1:0] REG_A2_A3 = 3'd3;
   localparam logic [REG_IDX_W-1:0] REG_A4    = 3'd4;

   // reset values: 200..3000 Hz butterworth bandpass
   localparam logic [REG_W-1:0] RST_B0_B1 = 48'd18978;
   localparam logic [REG_W-1:0] RST_B2_B3 = 48'd16739260;
   localparam logic [REG_W-1:0] RST_B4_A1 = 48'd222325542767138;
   localparam logic [REG_W-1:0] RST_A2_A3 = 48'd237327767409590;
   localparam logic [A4_W-1:0]  RST_A4    = 24'd549239;

   // delay register indexes
   localparam logic [DLY_IDX_W-1:0] DLY_ONE   = 2'd0;
   localparam logic [DLY_IDX_W-1:0] DLY_TWO   = 2'd1;
   localparam logic [DLY_IDX_W-1:0] DLY_THREE = 2'd2;
   localparam logic [DLY_IDX_W-1:0] DLY_FOUR  = 2'd3;

   // coefficient order matches the packing of the registers
   typedef enum logic [3:0] {
      COEF_B0, COEF_B1, COEF_B2, COEF_B3, COEF_B4,
      COEF_A1, COEF_A2, COEF_A3, COEF_A4
   } coef_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD_DLY,
      ACC_LOAD_PROD,
      ACC_SUB
   } acc_op_type;

   typedef logic [COEF_N-1:0][COEF_W-1:0] coef_set_type;

   typedef struct packed {
      logic                 x_ld;
      logic                 mul_en;
      coef_sel_type         coef_sel;
      logic                 use_y;
      acc_op_type           acc_op;
      logic [DLY_IDX_W-1:0] dly_rd;
      logic                 y_ld;
      logic                 dly_wr;
      logic [DLY_IDX_W-1:0] dly_wr_idx;
   } mac_ctrl_type;

endpackage

// ----- hw/rtl/iir4_csr.sv -----
// ----------------------------------------------------------------------------
// iir4_csr
// coefficient registers behind the apb-style configuration port
// ----------------------------------------------------------------------------
module iir4_csr
   import iir4_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output coef_set_type          coefs
);

   logic [REG_W-1:0] b0_b1_ff;
   logic [REG_W-1:0] b2_b3_ff;
   logic [REG_W-1:0] b4_a1_ff;
   logic [REG_W-1:0] a2_a3_ff;
   logic [A4_W-1:0]  a4_ff;
   logic [REG_IDX_W-1:0] reg_idx;
   logic wr_en;

   assign csr_pready = 1'b1;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1 -: REG_IDX_W];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         b0_b1_ff <= RST_B0_B1;
         b2_b3_ff <= RST_B2_B3;
         b4_a1_ff <= RST_B4_A1;
         a2_a3_ff <= RST_A2_A3;
         a4_ff    <= RST_A4;
      end else if (wr_en) begin
         unique case (reg_idx)
            REG_B0_B1: b0_b1_ff <= csr_pwdata[REG_W-1:0];
            REG_B2_B3: b2_b3_ff <= csr_pwdata[REG_W-1:0];
            REG_B4_A1: b4_a1_ff <= csr_pwdata[REG_W-1:0];
            REG_A2_A3: a2_a3_ff <= csr_pwdata[REG_W-1:0];
            REG_A4:    a4_ff    <= csr_pwdata[A4_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_B0_B1: csr_prdata = CSR_DATA_W'(b0_b1_ff);
         REG_B2_B3: csr_prdata = CSR_DATA_W'(b2_b3_ff);
         REG_B4_A1: csr_prdata = CSR_DATA_W'(b4_a1_ff);
         REG_A2_A3: csr_prdata = CSR_DATA_W'(a2_a3_ff);
         REG_A4:    csr_prdata = CSR_DATA_W'(a4_ff);
         default:   csr_prdata = '0;
      endcase
   end

   // packing order gives b0..b4 then a1..a4
   assign coefs = {a4_ff, a2_a3_ff, b4_a1_ff, b2_b3_ff, b0_b1_ff};

endmodule

// ----- hw/rtl/iir4_mac.sv -----
// ----------------------------------------------------------------------------
// iir4_mac
// shared 24x16 multiplier and 44-bit accumulator with the four delay
// registers, output rounding and delay saturation
// ----------------------------------------------------------------------------
module iir4_mac
   import iir4_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  mac_ctrl_type               ctrl,
   input  coef_set_type               coefs,
   input  logic signed [SAMPLE_W-1:0] x_in,
   output logic signed [SAMPLE_W-1:0] y_out
);

   localparam logic [SAMPLE_W-1:0] Y_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
   localparam logic [SAMPLE_W-1:0] Y_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};
   localparam logic [DELAY_W-1:0]  D_MAX = {1'b0, {(DELAY_W-1){1'b1}}};
   localparam logic [DELAY_W-1:0]  D_MIN = {1'b1, {(DELAY_W-1){1'b0}}};
   localparam logic [ACC_W-1:0]    HALF  = ACC_W'(1) << (FRAC_SHIFT - 1);
   localparam int                  Y_TOP = FRAC_SHIFT + SAMPLE_W - 1;

   logic [SAMPLE_W-1:0] x_ff;
   logic [SAMPLE_W-1:0] y_ff;
   logic [PROD_W-1:0]   prod_ff;
   logic [PROD_W-1:0]   prod_in;
   logic [ACC_W-1:0]    acc_ff;
   logic [ACC_W-1:0]    acc_in;
   logic [DELAY_N-1:0][DELAY_W-1:0] dly_ff;

   logic [COEF_W-1:0]   coef_op;
   logic [SAMPLE_W-1:0] smp_op;
   logic [ACC_W-1:0]    prod_ext;
   logic [ACC_W-1:0]    dly_ext;
   logic [ACC_W-1:0]    rnd;
   logic [SAMPLE_W-1:0] y_in;
   logic [DELAY_W-1:0]  dly_in;

   assign coef_op = coefs[ctrl.coef_sel];
   assign smp_op  = ctrl.use_y ? y_ff : x_ff;

   // signed 24x16 product, exact in 40 bits
   assign prod_in = $signed(coef_op) * $signed(smp_op);

   assign prod_ext = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
   assign dly_ext  = {{(ACC_W-DELAY_W){dly_ff[ctrl.dly_rd][DELAY_W-1]}},
                      dly_ff[ctrl.dly_rd]};

   always_comb begin
      unique case (ctrl.acc_op)
         ACC_HOLD:      acc_in = acc_ff;
         ACC_LOAD_DLY:  acc_in = dly_ext + prod_ext;
         ACC_LOAD_PROD: acc_in = prod_ext;
         ACC_SUB:       acc_in = acc_ff - prod_ext;
         default:       acc_in = acc_ff;
      endcase
   end

   // round half up, then saturate to 16 bits
   assign rnd = acc_ff + HALF;
   always_comb begin
      if ((&rnd[ACC_W-1:Y_TOP]) || !(|rnd[ACC_W-1:Y_TOP])) begin
         y_in = rnd[Y_TOP:FRAC_SHIFT];
      end else if (rnd[ACC_W-1]) begin
         y_in = Y_MIN;
      end else begin
         y_in = Y_MAX;
      end
   end

   always_comb begin
      if ((&acc_ff[ACC_W-1:DELAY_W-1]) || !(|acc_ff[ACC_W-1:DELAY_W-1])) begin
         dly_in = acc_ff[DELAY_W-1:0];
      end else if (acc_ff[ACC_W-1]) begin
         dly_in = D_MIN;
      end else begin
         dly_in = D_MAX;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.x_ld) begin
         x_ff <= x_in;
      end
      if (ctrl.mul_en) begin
         prod_ff <= prod_in;
      end
      if (ctrl.y_ld) begin
         y_ff <= y_in;
      end
      acc_ff <= acc_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dly_ff <= '0;
      end else if (ctrl.dly_wr) begin
         dly_ff[ctrl.dly_wr_idx] <= dly_in;
      end
   end

   assign y_out = y_ff;

endmodule

// ----- hw/rtl/iir4_seq.sv -----
// ----------------------------------------------------------------------------
// iir4_seq
// step sequencer for the shared multiply-accumulate unit and the
// request / result handshakes
// ----------------------------------------------------------------------------
module iir4_seq
   import iir4_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   input  logic                req_tlast,
   output logic                req_tready,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [SAMPLE_W-1:0] rsp_tdata,
   output logic                rsp_tlast,
   input  logic [SAMPLE_W-1:0] y_in,
   output mac_ctrl_type        ctrl
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL_B0,
      ST_ADD_D1,
      ST_ROUND,
      ST_ADD_D2,
      ST_SUB_A1,
      ST_WR_D1,
      ST_SUB_A2,
      ST_WR_D2,
      ST_SUB_A3,
      ST_WR_D3,
      ST_SUB_A4,
      ST_WR_D4
   } state_type;

   state_type           state_ff, state_in;
   logic                last_ff;
   logic                rsp_valid_ff;
   logic [SAMPLE_W-1:0] rsp_data_ff;
   logic                rsp_last_ff;
   logic                post;

   assign req_tready = (state_ff == ST_IDLE);
   // result slot must be free before the last step can finish
   assign post = (state_ff == ST_WR_D4) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      ctrl          = '0;
      ctrl.coef_sel = COEF_B0;
      ctrl.acc_op   = ACC_HOLD;
      state_in      = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            ctrl.x_ld = req_tvalid;
            if (req_tvalid) begin
               state_in = ST_MUL_B0;
            end
         end
         ST_MUL_B0: begin
            ctrl.mul_en   = 1'b1;
            ctrl.coef_sel = COEF_B0;
            state_in      = ST_ADD_D1;
         end
         ST_ADD_D1: begin
            ctrl.acc_op = ACC_LOAD_DLY;
            ctrl.dly_rd = DLY_ONE;
            state_in    = ST_ROUND;
         end
         ST_ROUND: begin
            ctrl.y_ld     = 1'b1;
            ctrl.mul_en   = 1'b1;
            ctrl.coef_sel = COEF_B1;
            state_in      = ST_ADD_D2;
         end
         ST_ADD_D2: begin
            ctrl.acc_op   = ACC_LOAD_DLY;
            ctrl.dly_rd   = DLY_TWO;
            ctrl.mul_en   = 1'b1;
            ctrl.coef_sel = COEF_A1;
            ctrl.use_y    = 1'b1;
            state_in      = ST_SUB_A1;
         end
         ST_SUB_A1: begin
            ctrl.acc_op   = ACC_SUB;
            ctrl.mul_en   = 1'b1;
            ctrl.coef_sel = COEF_B2;
            state_in      = ST_WR_D1;
         end
         ST_WR_D1: begin
            ctrl.dly_wr     = 1'b1;
            ctrl.dly_wr_idx = DLY_ONE;
            ctrl.acc_op     = ACC_LOAD_DLY;
            ctrl.dly_rd     = DLY_THREE;
            ctrl.mul_en     = 1'b1;
            ctrl.coef_sel   = COEF_A2;
            ctrl.use_y      = 1'b1;
            state_in        = ST_SUB_A2;
         end
         ST_SUB_A2: begin
            ctrl.acc_op   = ACC_SUB;
            ctrl.mul_en   = 1'b1;
            ctrl.coef_sel = COEF_B3;
            state_in      = ST_WR_D2;
         end
         ST_WR_D2: begin
            ctrl.dly_wr     = 1'b1;
            ctrl.dly_wr_idx = DLY_TWO;
            ctrl.acc_op     = ACC_LOAD_DLY;
            ctrl.dly_rd     = DLY_FOUR;
            ctrl.mul_en     = 1'b1;
            ctrl.coef_sel   = COEF_A3;
            ctrl.use_y      = 1'b1;
            state_in        = ST_SUB_A3;
         end
         ST_SUB_A3: begin
            ctrl.acc_op   = ACC_SUB;
            ctrl.mul_en   = 1'b1;
            ctrl.coef_sel = COEF_B4;
            state_in      = ST_WR_D3;
         end
         ST_WR_D3: begin
            ctrl.dly_wr     = 1'b1;
            ctrl.dly_wr_idx = DLY_THREE;
            ctrl.acc_op     = ACC_LOAD_PROD;
            ctrl.mul_en     = 1'b1;
            ctrl.coef_sel   = COEF_A4;
            ctrl.use_y      = 1'b1;
            state_in        = ST_SUB_A4;
         end
         ST_SUB_A4: begin
            ctrl.acc_op = ACC_SUB;
            state_in    = ST_WR_D4;
         end
         ST_WR_D4: begin
            // accumulator holds, so a repeated write while stalled is harmless
            ctrl.dly_wr     = 1'b1;
            ctrl.dly_wr_idx = DLY_FOUR;
            if (post) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (post) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (req_tvalid && req_tready) begin
         last_ff <= req_tlast;
      end
      if (post) begin
         rsp_data_ff <= y_in;
         rsp_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// ----- hw/rtl/iir_fourth_order_df2t_filter.sv -----
// ----------------------------------------------------------------------------
// iir_fourth_order_df2t_filter
// fourth-order direct form ii transposed iir filter, q1.15 in and out
// ----------------------------------------------------------------------------
// One request carries one Q1.15 sample and gives one filtered Q1.15 sample.
// All nine products go through a single 24x16 multiplier and a 44-bit
// accumulator, stepped by a sequencer: a request is taken while the block
// is idle, the result is registered as the last step finishes, and a new
// request is taken in the cycle after that. The result waits in an output
// register; the last step only finishes once that register is free. The
// user must write coefficients through the configuration port (64-bit data,
// registers at byte addresses 0, 8, 16, 24 and 32) only while no request is
// in flight; the block does not enforce it. Delay registers clear on reset.
module iir_fourth_order_df2t_filter
   import iir4_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [15:0]           req_tdata,   // [15:0] sample_in
   input  logic                  req_tlast,   // block_end_in
   // result channel
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [15:0]           rsp_tdata,   // [15:0] sample_out
   output logic                  rsp_tlast,   // block_end_out
   // configuration port
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   coef_set_type        coefs;
   mac_ctrl_type        ctrl;
   logic [SAMPLE_W-1:0] y_val;

   iir4_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .coefs       (coefs)
   );

   iir4_mac u_mac (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .coefs (coefs),
      .x_in  (req_tdata[SAMPLE_W-1:0]),
      .y_out (y_val)
   );

   iir4_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .y_in       (y_val),
      .ctrl       (ctrl)
   );

endmodule
